[rtl/lrupr_pkg.sv]
// Shared constants and transaction types for the LRU page replacement block.
`default_nettype none
package lrupr_pkg;

	// Number of frames and width of a page number.
	localparam int MAX_FRAMES = 16;
	localparam int PAGE_BITS  = 20;

	// Width of the frame-count configuration register.
	localparam int CFG_W = 5;

	// Frame index and recency rank widths (ranks run from 0 to MAX_FRAMES-1).
	localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int RANK_W = IDX_W;

	// Reset value of the frame-count register.
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(MAX_FRAMES);

	// Running search result handed from one cell to the next.
	typedef struct packed {
		logic [PAGE_BITS-1:0] page;
		logic                 hit;
		logic [IDX_W-1:0]     hit_idx;
		logic [RANK_W-1:0]    hit_rank;
		logic                 emp;
		logic [IDX_W-1:0]     emp_idx;
		logic                 have_best;
		logic [IDX_W-1:0]     best_idx;
		logic [RANK_W-1:0]    best_rank;
	} link_t;

	// Update broadcast to every cell once a search has finished.
	typedef struct packed {
		logic                 en;
		logic [IDX_W-1:0]     idx;
		logic [RANK_W-1:0]    rank;
		logic                 fresh;
		logic [PAGE_BITS-1:0] page;
	} upd_t;

endpackage
`default_nettype wire

[rtl/lru_page_replacement.sv]
// Top level of the fully associative LRU page store: cell chain and control.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------
//   input    | in_valid / in_stall  | page_number
//   output   | out_valid / out_stall| missed_page, filled_slot
//   config   | cfg_we               | cfg_wdata (active frame count)
//
// The search walks the chain of frame cells one cell per cycle, then an
// update step broadcasts the recency update. A hit gives no output
// transaction.
// Reset empties all frames, clears all ranks and sets the frame count to 16.
// A stalled output holds the update step of a miss until the register drains.
`default_nettype none
module lru_page_replacement import lrupr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PAGE_BITS-1:0] page_number,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PAGE_BITS-1:0] missed_page,
	output logic [IDX_W-1:0]     filled_slot,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPD
	} state_t;

	state_t                state_q;
	logic [CFG_W-1:0]      active_entries_q;
	logic                  out_valid_q;
	logic [PAGE_BITS-1:0]  missed_page_q;
	logic [IDX_W-1:0]      filled_slot_q;
	link_t                 res_q;

	logic [MAX_FRAMES:0]   chain_vld;
	link_t                 chain_link [MAX_FRAMES+1];
	link_t                 head_link;
	logic [MAX_FRAMES-1:0] active;
	logic [31:0]           cfg_ext;
	logic [31:0]           frame_cnt;
	logic                  accept;
	logic                  go;
	logic [IDX_W-1:0]      slot;
	upd_t                  upd;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_entries_q <= CFG_RESET;
		end else if (cfg_we) begin
			active_entries_q <= cfg_wdata;
		end
	end

	// Clamp the frame count to the range 1 to MAX_FRAMES.
	assign cfg_ext = 32'(active_entries_q);
	always_comb begin
		if (cfg_ext == 32'd0) begin
			frame_cnt = 32'd1;
		end else if (cfg_ext > 32'(MAX_FRAMES)) begin
			frame_cnt = 32'(MAX_FRAMES);
		end else begin
			frame_cnt = cfg_ext;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Launch a fresh search transaction into the head of the chain.
	always_comb begin
		head_link      = '0;
		head_link.page = page_number;
	end

	assign chain_link[0] = head_link;
	assign chain_vld[0]  = accept;

	// Row of frame cells.
	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		assign active[i] = (32'(i) < frame_cnt);

		lrupr_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cell_idx     (IDX_W'(i)),
			.active       (active[i]),
			.link_vld_in  (chain_vld[i]),
			.link_in      (chain_link[i]),
			.link_vld_out (chain_vld[i+1]),
			.link_out     (chain_link[i+1]),
			.upd          (upd)
		);
	end

	// Hold the finished search result for the update step.
	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN) && chain_vld[MAX_FRAMES]) begin
			res_q <= chain_link[MAX_FRAMES];
		end
	end

	// Pick the frame to touch and broadcast the update.
	assign slot = res_q.emp ? res_q.emp_idx : res_q.best_idx;
	assign go   = (state_q == ST_UPD) && (res_q.hit || !out_valid_q || !out_stall);

	always_comb begin
		upd.en    = go;
		upd.idx   = res_q.hit ? res_q.hit_idx : slot;
		upd.rank  = res_q.hit ? res_q.hit_rank : res_q.best_rank;
		upd.fresh = !res_q.hit && res_q.emp;
		upd.page  = res_q.page;
	end

	// Control state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			missed_page_q <= '0;
			filled_slot_q <= '0;
		end else begin
			// A miss loads the output register; otherwise a taken output empties it.
			if (go && !res_q.hit) begin
				out_valid_q   <= 1'b1;
				missed_page_q <= res_q.page;
				filled_slot_q <= slot;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (chain_vld[MAX_FRAMES]) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign missed_page = missed_page_q;
	assign filled_slot = filled_slot_q;

	// Only one search transaction is ever in the chain.
	a_one_search: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chain_vld))
		else $error("more than one search in the cell chain");

	// The end of the chain only produces a result while a search is running.
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain_vld[MAX_FRAMES] |-> (state_q == ST_SCAN))
		else $error("search result outside of a scan");

	// A miss update always loads the output register.
	a_miss_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(upd.en && !res_q.hit) |=> out_valid)
		else $error("miss did not produce an output transaction");

	// A new output only appears right after the update step.
	a_out_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_UPD))
		else $error("output raised outside of the update step");

endmodule
`default_nettype wire

[rtl/lrupr_cell.sv]
// One frame cell: holds a page, its valid bit and its recency rank, and
// advances the running search by one step.
`default_nettype none
module lrupr_cell import lrupr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] cell_idx,
	input  logic             active,
	input  logic             link_vld_in,
	input  link_t            link_in,
	output logic             link_vld_out,
	output link_t            link_out,
	input  upd_t             upd
);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic [RANK_W-1:0]    rank_q;
	logic                 link_vld_q;
	link_t                link_q;
	link_t                link_nxt;
	logic                 mine;

	// Fold this frame into the search: first hit, first empty, oldest frame.
	always_comb begin
		link_nxt = link_in;
		if (active) begin
			if (valid_q && (page_q == link_in.page) && !link_in.hit) begin
				link_nxt.hit      = 1'b1;
				link_nxt.hit_idx  = cell_idx;
				link_nxt.hit_rank = rank_q;
			end
			if (!valid_q && !link_in.emp) begin
				link_nxt.emp     = 1'b1;
				link_nxt.emp_idx = cell_idx;
			end
			if (!link_in.have_best || (rank_q > link_in.best_rank)) begin
				link_nxt.have_best = 1'b1;
				link_nxt.best_idx  = cell_idx;
				link_nxt.best_rank = rank_q;
			end
		end
	end

	// The search transaction moves one cell along per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q <= 1'b0;
		end else begin
			link_vld_q <= link_vld_in;
		end
	end

	always_ff @(posedge clk) begin
		link_q <= link_nxt;
	end

	assign link_vld_out = link_vld_q;
	assign link_out     = link_q;

	assign mine = (upd.idx == cell_idx);

	// Recency update: the touched frame becomes rank zero, younger frames age (all valid frames on a fresh fill).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd.en) begin
			if (mine) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (valid_q && (upd.fresh || (rank_q < upd.rank))) begin
				rank_q <= rank_q + RANK_W'(1);
			end
		end
	end

	// Page contents are written whenever the frame is touched; a hit writes back the page it already holds.
	always_ff @(posedge clk) begin
		if (upd.en && mine) begin
			page_q <= upd.page;
		end
	end

endmodule
`default_nettype wire

[dv/lru_page_replacement_tb.sv]
// Self-checking testbench for the LRU page replacement block with a built-in frame predictor.
`default_nettype none
module lru_page_replacement_tb;
	import lrupr_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 12;
	localparam int REF_CYCLES     = MAX_FRAMES + 2;
	localparam int SETTLE_CYCLES  = 2 * REF_CYCLES + 4;
	localparam int TIMEOUT_CYCLES = 1000000;
	localparam int IDLE_PERCENT   = 22;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_REFS     = 134;
	localparam int POOL_SIZE      = 24;
	localparam int REPORT_LIMIT   = 10;
	localparam int NO_FRAME       = -1;

	// Kinds of entry in the sender's work list.
	typedef enum logic [1:0] {
		ITEM_PAGE,
		ITEM_SET_FRAMES,
		ITEM_WAIT_DRAIN
	} item_kind_t;

	typedef struct {
		item_kind_t           kind;
		logic [PAGE_BITS-1:0] value;
	} ref_entry_t;

	typedef struct {
		logic [PAGE_BITS-1:0] page;
		logic [IDX_W-1:0]     slot;
	} fill_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [PAGE_BITS-1:0] page_number = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [PAGE_BITS-1:0] missed_page;
	logic [IDX_W-1:0]     filled_slot;
	logic                 cfg_we = 1'b0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	// Predictor copy of the frame store and of the frame-count register.
	logic [PAGE_BITS-1:0] frame_pg   [MAX_FRAMES];
	bit                   frame_full [MAX_FRAMES];
	int                   frame_age  [MAX_FRAMES];
	logic [CFG_W-1:0]     frames_setting = CFG_RESET;

	ref_entry_t           refs_to_send [$];
	fill_t                fills_due [$];
	logic [PAGE_BITS-1:0] page_pool [POOL_SIZE];

	int fills_owed    = 0;
	int quiet_cycles  = 0;
	int gap_left      = 0;
	int pages_offered = 0;
	int rx_cycle      = 0;
	int mismatches    = 0;
	int refs_taken    = 0;
	int fills_checked = 0;
	int hits_seen     = 0;
	int settings_done = 0;

	lru_page_replacement u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.page_number (page_number),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.missed_page (missed_page),
		.filled_slot (filled_slot),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	// Free-running clock.
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Reset is asserted once at the start, then released between edges.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Hard limit on the run time.
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("timeout: %0d fills still owed, %0d references unsent", fills_due.size(),
			refs_to_send.size());
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int frames_in_use();
		if (frames_setting < 1)
			return 1;
		if (frames_setting > MAX_FRAMES)
			return MAX_FRAMES;
		return int'(frames_setting);
	endfunction

	// Makes frame e the most recent; a fresh fill ages every other valid frame.
	function automatic void promote_frame(int e, bit fresh);
		int r;
		r = frame_age[e];
		for (int i = 0; i < MAX_FRAMES; i++) begin
			if (i != e && frame_full[i] && (fresh || frame_age[i] < r))
				frame_age[i] = frame_age[i] + 1;
		end
		frame_age[e] = 0;
	endfunction

	// Looks one page up and updates the frame store; returns 1 on a fill.
	function automatic bit predict_fill(input logic [PAGE_BITS-1:0] pg,
		output logic [IDX_W-1:0] slot);
		int n;
		int hit_at;
		int empty_at;
		int e;
		n = frames_in_use();
		hit_at = NO_FRAME;
		empty_at = NO_FRAME;
		slot = '0;
		for (int i = 0; i < n; i++) begin
			if (hit_at == NO_FRAME && frame_full[i] && frame_pg[i] == pg)
				hit_at = i;
		end
		if (hit_at != NO_FRAME) begin
			promote_frame(hit_at, 1'b0);
			return 1'b0;
		end
		for (int i = 0; i < n; i++) begin
			if (empty_at == NO_FRAME && !frame_full[i])
				empty_at = i;
		end
		if (empty_at != NO_FRAME) begin
			e = empty_at;
			promote_frame(e, 1'b1);
			frame_full[e] = 1'b1;
		end else begin
			// The oldest active frame is the victim; ties go to the lowest index.
			e = 0;
			for (int i = 1; i < n; i++) begin
				if (frame_age[i] > frame_age[e])
					e = i;
			end
			promote_frame(e, 1'b0);
		end
		frame_pg[e] = pg;
		slot = IDX_W'(e);
		return 1'b1;
	endfunction

	task automatic add_page(input logic [PAGE_BITS-1:0] pg);
		refs_to_send.push_back('{ITEM_PAGE, pg});
	endtask

	task automatic add_setting(input logic [CFG_W-1:0] frames);
		refs_to_send.push_back('{ITEM_SET_FRAMES, PAGE_BITS'(frames)});
	endtask

	task automatic add_drain();
		refs_to_send.push_back('{ITEM_WAIT_DRAIN, '0});
	endtask

	// Sender: offers pages, writes the frame count when idle, pauses on drain points.
	always @(posedge clk) begin : drive_refs
		logic                 nxt_valid;
		logic [PAGE_BITS-1:0] nxt_page;
		logic                 nxt_we;
		logic [CFG_W-1:0]     nxt_wdata;
		nxt_valid = in_valid;
		nxt_page = page_number;
		nxt_we = 1'b0;
		nxt_wdata = cfg_wdata;
		if (arst_n) begin
			// A taken transaction may be followed by a gap of random length.
			if (in_valid && !in_stall) begin
				nxt_valid = 1'b0;
				if (pages_offered >= 700 && pages_offered < 1000)
					gap_left = 0;
				else if ($urandom_range(0, 99) < IDLE_PERCENT)
					gap_left = $urandom_range(1, 2 * REF_CYCLES);
				else
					gap_left = 0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
				end else if (refs_to_send.size() > 0) begin
					case (refs_to_send[0].kind)
						ITEM_PAGE: begin
							nxt_valid = 1'b1;
							nxt_page = refs_to_send[0].value;
							pages_offered = pages_offered + 1;
							void'(refs_to_send.pop_front());
						end
						ITEM_SET_FRAMES: begin
							if (!in_valid && quiet_cycles >= SETTLE_CYCLES) begin
								nxt_we = 1'b1;
								nxt_wdata = refs_to_send[0].value[CFG_W-1:0];
								void'(refs_to_send.pop_front());
							end
						end
						default: begin
							if (!in_valid && fills_owed == 0)
								void'(refs_to_send.pop_front());
						end
					endcase
				end
			end
		end
		in_valid <= nxt_valid;
		page_number <= nxt_page;
		cfg_we <= nxt_we;
		cfg_wdata <= nxt_wdata;
	end

	// Receiver: random stalls, two long hold-offs and one stretch without stalls.
	always @(posedge clk) begin : drive_stall
		if (arst_n) begin
			rx_cycle <= rx_cycle + 1;
			if ((rx_cycle >= 4000 && rx_cycle < 4400) || (rx_cycle >= 18000 && rx_cycle < 18400))
				out_stall <= 1'b1;
			else if (rx_cycle >= 9000 && rx_cycle < 13000)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
		end
	end

	// Monitor: checks output transactions, then predicts from input transactions.
	always @(posedge clk) begin : watch_ports
		fill_t            want;
		logic [IDX_W-1:0] slot;
		if (arst_n) begin
			if (cfg_we) begin
				frames_setting = cfg_wdata;
				settings_done = settings_done + 1;
			end
			if (out_valid && !out_stall) begin
				if (fills_due.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: unexpected fill page=%h slot=%0d", $realtime, missed_page,
							filled_slot);
					mismatches = mismatches + 1;
				end else begin
					want = fills_due.pop_front();
					fills_checked = fills_checked + 1;
					if (missed_page !== want.page || filled_slot !== want.slot) begin
						if (mismatches < REPORT_LIMIT)
							$display("%0t: fill mismatch page exp=%h got=%h slot exp=%0d got=%0d",
								$realtime, want.page, missed_page, want.slot, filled_slot);
						mismatches = mismatches + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				refs_taken = refs_taken + 1;
				if (predict_fill(page_number, slot))
					fills_due.push_back('{page_number, slot});
				else
					hits_seen = hits_seen + 1;
			end
			fills_owed <= fills_due.size();
			if (!in_valid && !out_valid && fills_due.size() == 0)
				quiet_cycles <= quiet_cycles + 1;
			else
				quiet_cycles <= 0;
		end
	end

	// Builds the reference stream, then waits for the block to go quiet and reports.
	initial begin : build_refs
		int span;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			frame_pg[i] = '0;
			frame_full[i] = 1'b0;
			frame_age[i] = 0;
		end
		for (int i = 0; i < POOL_SIZE; i++)
			page_pool[i] = PAGE_BITS'($urandom);

		// Extreme pages and an early hit on the first frame.
		add_page(20'h00000);
		add_page(20'hFFFFF);
		add_page(20'h00000);
		add_page(20'h55555);
		add_page(20'hAAAAA);
		// A zero frame count behaves as one frame.
		add_setting(5'd0);
		add_page(20'h00001);
		add_page(20'h00001);
		// One frame: every new page replaces slot zero.
		add_setting(5'd1);
		add_page(20'h12345);
		add_page(20'h12345);
		add_page(20'hAAAAA);
		// Above the maximum: the range grows back and a page sits in two frames.
		add_setting(5'd31);
		add_page(20'hAAAAA);
		add_page(20'h55555);
		add_page(20'h77777);
		// Three frames full: replacement must pick the least recently used one.
		add_setting(5'd3);
		add_page(20'h00002);
		add_page(20'h00003);
		add_page(20'h00002);
		add_page(20'h00004);
		add_page(20'h00003);
		add_setting(5'd16);
		add_page(20'h0F0F0);
		add_page(20'hF0F0F);

		// Random phases: mostly reuse of a small page set, some fully random pages.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			logic [CFG_W-1:0] frames;
			int               eff;
			case (ph)
				3:       frames = 5'd0;
				6:       frames = 5'd31;
				9:       frames = 5'd1;
				11:      frames = 5'd16;
				default: begin
					if ($urandom_range(0, 4) == 0)
						frames = CFG_W'($urandom_range(MAX_FRAMES + 1, 31));
					else
						frames = CFG_W'($urandom_range(1, MAX_FRAMES));
				end
			endcase
			add_setting(frames);
			eff = (frames < 1) ? 1 : ((frames > MAX_FRAMES) ? MAX_FRAMES : int'(frames));
			span = eff + $urandom_range(0, 4);
			if (span > POOL_SIZE)
				span = POOL_SIZE;
			for (int k = 0; k < 6; k++)
				page_pool[$urandom_range(0, POOL_SIZE - 1)] = PAGE_BITS'($urandom);
			for (int j = 0; j < PHASE_REFS; j++) begin
				if (j == PHASE_REFS / 2)
					add_drain();
				if ($urandom_range(0, 99) < 75)
					add_page(page_pool[$urandom_range(0, span - 1)]);
				else
					add_page(PAGE_BITS'($urandom));
			end
		end

		// Let the stream run out and the block settle.
		while (refs_to_send.size() > 0 || in_valid)
			@(posedge clk);
		while (fills_owed != 0 || quiet_cycles < SETTLE_CYCLES)
			@(posedge clk);

		$display("covered %0d page references: %0d fills checked, %0d hits", refs_taken,
			fills_checked, hits_seen);
		$display("frame count written %0d times, mismatches found: %0d", settings_done,
			mismatches);
		if (mismatches == 0 && fills_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire
